// ===== rtl/core/pbskip_pkg.sv =====
// Shared types and codes for the protobuf wire-format field skipper.
package pbskip_pkg;

  typedef enum logic [1:0] {
    PH_TAG    = 2'd0,
    PH_VALUE  = 2'd1,
    PH_LENGTH = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  // Wire types.
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LENGTH  = 3'd2;
  localparam logic [2:0] WT_SGROUP  = 3'd3;
  localparam logic [2:0] WT_EGROUP  = 3'd4;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // Result status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FIELD_ZERO = 3'd1;
  localparam logic [2:0] ST_BAD_WIRE   = 3'd2;
  localparam logic [2:0] ST_LONG_VINT  = 3'd3;
  localparam logic [2:0] ST_OVER_32    = 3'd4;
  localparam logic [2:0] ST_UNMATCHED  = 3'd5;
  localparam logic [2:0] ST_TOO_DEEP   = 3'd6;
  localparam logic [2:0] ST_UNEXP_END  = 3'd7;

  localparam logic [3:0] VINT_LAST_IDX = 4'd9;
  localparam logic [6:0] NEST_RESET    = 7'd64;

endpackage

// ===== rtl/core/protobuf_wire_field_skipper_top.sv =====
// Top level of the protobuf wire-format field skipper with its group stack memory.
// A result appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; s_tready drops only while a result waits on m_tready.
// The group stack is a one-port-write, one-port-read memory whose top entry is
// prefetched every cycle, with a bypass for an entry written in the same cycle.
// Reset (rst, synchronous) clears the parser state and sets nesting_limit to 64;
// the stack memory is not cleared, only entries below the depth are ever read.
module protobuf_wire_field_skipper_top
  import pbskip_pkg::*;
#(
  parameter int MAX_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [28:0] field_number, [31:29] wire_kind, [38:32] nest_depth, [41:39] status,
  // [47:42] zero
  output logic [47:0] m_tdata,
  output logic        m_tlast,   // message_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int CW = (DW > 7) ? DW : 7;
  localparam logic [CW-1:0] MAXD = CW'(MAX_DEPTH);

  // Registers.
  logic [6:0]    nesting_limit;
  phase_t        phase, phase_next;
  logic [31:0]   acc;
  logic          acc_ovf;
  logic [3:0]    vcnt;
  logic [28:0]   field_num, field_num_next;
  logic [2:0]    wkind, wkind_next;
  logic [31:0]   skip_left, skip_left_next;
  logic [DW-1:0] depth, depth_next;
  logic          failed;

  logic [28:0]   stack_mem [MAX_DEPTH];
  logic [28:0]   rd_q;
  logic [28:0]   byp_d;
  logic          byp_sel;

  logic s_fire, take;
  assign s_fire    = s_tvalid && s_tready;
  assign take      = s_fire && !failed;
  assign s_tready  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      nesting_limit <= NEST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      nesting_limit <= cfg_data;
    end
  end

  // Varint byte decode, shared by the tag, value and length phases.
  logic [31:0] add_lo;
  logic        add_hi;
  logic [31:0] val_lo;
  logic        val_hi;
  logic        cont, too_long, complete;
  logic [28:0] tag_fn;
  logic [2:0]  tag_wk;

  always_comb begin
    add_lo = '0;
    add_hi = 1'b0;
    case (vcnt) inside
      4'd0: add_lo = {25'd0, s_tdata[6:0]};
      4'd1: add_lo = {18'd0, s_tdata[6:0], 7'd0};
      4'd2: add_lo = {11'd0, s_tdata[6:0], 14'd0};
      4'd3: add_lo = {4'd0, s_tdata[6:0], 21'd0};
      4'd4: begin
        add_lo = {s_tdata[3:0], 28'd0};
        add_hi = |s_tdata[6:4];
      end
      [4'd5:4'd8]: add_hi = |s_tdata[6:0];
      4'd9: add_hi = s_tdata[0];   // only bit 63 survives on the tenth byte
      default: ;
    endcase
    val_lo   = acc | add_lo;
    val_hi   = acc_ovf | add_hi;
    cont     = s_tdata[7];
    too_long = cont && (vcnt == VINT_LAST_IDX);
    complete = !cont;
    tag_fn   = val_lo[31:3];
    tag_wk   = val_lo[2:0];
  end

  // Stack top and nesting checks.
  logic [28:0]   stack_top;
  logic [CW-1:0] depth_ext, lim_ext;
  logic          too_deep, pop_ok;

  always_comb begin
    stack_top = byp_sel ? byp_d : rd_q;
    depth_ext = CW'(depth);
    lim_ext   = CW'(nesting_limit);
    if (lim_ext > MAXD) lim_ext = MAXD;
    too_deep  = (depth_ext >= lim_ext) || (depth_ext >= MAXD);
    pop_ok    = (depth != '0) && (stack_top == tag_fn);
  end

  // Next state.
  logic        push;
  logic [31:0] skip_dec;

  always_comb begin
    phase_next     = phase;
    field_num_next = field_num;
    wkind_next     = wkind;
    skip_left_next = skip_left;
    depth_next     = depth;
    push           = 1'b0;
    skip_dec       = (skip_left != '0) ? skip_left - 32'd1 : 32'd0;
    unique case (phase)
      PH_TAG: begin
        if (complete && !val_hi) begin
          field_num_next = tag_fn;
          wkind_next     = tag_wk;
          if (tag_fn != '0) begin
            unique case (tag_wk) inside
              WT_VARINT:  phase_next = PH_VALUE;
              WT_FIXED64: begin
                skip_left_next = 32'd8;
                phase_next     = PH_SKIP;
              end
              WT_FIXED32: begin
                skip_left_next = 32'd4;
                phase_next     = PH_SKIP;
              end
              WT_LENGTH:  phase_next = PH_LENGTH;
              WT_SGROUP: begin
                if (!too_deep) begin
                  push       = 1'b1;
                  depth_next = depth + DW'(1);
                end
              end
              WT_EGROUP: begin
                if (pop_ok) depth_next = depth - DW'(1);
              end
              default: ;
            endcase
          end
        end
      end
      PH_VALUE: begin
        if (complete) phase_next = PH_TAG;
      end
      PH_LENGTH: begin
        if (complete && !val_hi) begin
          if (val_lo == '0) begin
            phase_next = PH_TAG;
          end else begin
            skip_left_next = val_lo;
            phase_next     = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        skip_left_next = skip_dec;
        if (skip_dec == '0) phase_next = PH_TAG;
      end
      default: ;
    endcase
  end

  // Result for the accepted byte.
  logic [28:0] r_fn;
  logic [2:0]  r_wk;
  logic [2:0]  r_st;
  logic        r_err, r_done, emit;
  logic [CW-1:0] dn_ext;

  always_comb begin
    r_fn   = field_num;
    r_wk   = wkind;
    r_st   = ST_OK;
    r_err  = 1'b0;
    r_done = 1'b0;
    unique case (phase)
      PH_TAG: begin
        r_fn = '0;
        r_wk = '0;
        if (too_long) begin
          r_err = 1'b1;
          r_st  = ST_LONG_VINT;
        end else if (complete) begin
          if (val_hi) begin
            r_err = 1'b1;
            r_st  = ST_OVER_32;
          end else begin
            r_fn = tag_fn;
            r_wk = tag_wk;
            if (tag_fn == '0) begin
              r_err = 1'b1;
              r_st  = ST_FIELD_ZERO;
            end else begin
              unique case (tag_wk) inside
                WT_SGROUP: begin
                  if (too_deep) begin
                    r_err = 1'b1;
                    r_st  = ST_TOO_DEEP;
                  end else begin
                    r_done = 1'b1;
                  end
                end
                WT_EGROUP: begin
                  if (pop_ok) begin
                    r_done = 1'b1;
                  end else begin
                    r_err = 1'b1;
                    r_st  = ST_UNMATCHED;
                  end
                end
                WT_VARINT, WT_FIXED64, WT_FIXED32, WT_LENGTH: ;
                default: begin
                  r_err = 1'b1;
                  r_st  = ST_BAD_WIRE;
                end
              endcase
            end
          end
        end
      end
      PH_VALUE: begin
        if (too_long) begin
          r_err = 1'b1;
          r_st  = ST_LONG_VINT;
        end else if (complete) begin
          r_done = 1'b1;
        end
      end
      PH_LENGTH: begin
        if (too_long) begin
          r_err = 1'b1;
          r_st  = ST_LONG_VINT;
        end else if (complete) begin
          if (val_hi) begin
            r_err = 1'b1;
            r_st  = ST_OVER_32;
          end else if (val_lo == '0) begin
            r_done = 1'b1;
          end
        end
      end
      PH_SKIP: begin
        if (skip_dec == '0) r_done = 1'b1;
      end
      default: ;
    endcase
    // A last byte that leaves a field or a group open ends the message badly.
    if (!r_err && s_tlast && (!r_done || (depth_next != '0))) begin
      r_err = 1'b1;
      r_st  = ST_UNEXP_END;
    end
    emit   = r_err || r_done;
    dn_ext = CW'(depth_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TAG;
      acc       <= '0;
      acc_ovf   <= 1'b0;
      vcnt      <= '0;
      field_num <= '0;
      wkind     <= '0;
      skip_left <= '0;
      depth     <= '0;
      failed    <= 1'b0;
    end else if (take) begin
      phase     <= phase_next;
      field_num <= field_num_next;
      wkind     <= wkind_next;
      skip_left <= skip_left_next;
      depth     <= depth_next;
      if (r_err) failed <= 1'b1;
      if (phase != PH_SKIP) begin
        if (cont && !too_long) begin
          acc     <= val_lo;
          acc_ovf <= val_hi;
          vcnt    <= vcnt + 4'd1;
        end else begin
          acc     <= '0;
          acc_ovf <= 1'b0;
          vcnt    <= '0;
        end
      end
    end
  end

  // Group stack: the entry just below the coming depth is read every cycle, so
  // the top is ready for an end-group tag on the very next byte.
  logic [DW-1:0] depth_eff;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  always_comb begin
    depth_eff = take ? depth_next : depth;
    rd_addr   = (depth_eff == '0) ? '0 : AW'(depth_eff - DW'(1));
    wr_addr   = AW'(depth);
    wr_en     = take && push;
  end

  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[wr_addr] <= field_num_next;
    rd_q  <= stack_mem[rd_addr];
    byp_d <= field_num_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_sel <= 1'b0;
    end else begin
      byp_sel <= wr_en && (rd_addr == wr_addr);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      m_tdata <= {6'd0, r_st, dn_ext[6:0], r_wk, r_fn};
      m_tlast <= s_tlast;
    end
  end

endmodule

// ===== sim/protobuf_wire_field_skipper_top_test.sv =====
// Self-checking testbench for the protobuf wire-format field skipper top level.
`timescale 1ns / 100ps

module protobuf_wire_field_skipper_top_test
  import pbskip_pkg::*;
();

  localparam int STACK_DEPTH = 64;
  localparam int PART_BYTES  = 200;

  typedef enum int {VINT_MORE, VINT_DONE, VINT_TOO_LONG} vint_step_t;

  typedef enum int {
    ERR_FIELD_ZERO, ERR_BAD_WIRE, ERR_LONG_TAG, ERR_LONG_VALUE, ERR_TAG_OVER_32,
    ERR_LEN_OVER_32, ERR_UNMATCHED, ERR_TOO_DEEP, ERR_EARLY_END, ERR_NOISE
  } error_case_t;

  typedef struct packed {
    logic [28:0] fnum;
    logic [2:0]  wkind;
    logic [6:0]  depth;
    logic [2:0]  status;
    logic        done;
  } field_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = 7'd0;

  // Parser state as predicted from the bytes that were accepted.
  phase_t      ph = PH_TAG;
  logic [63:0] vacc = '0;
  int          vbytes = 0;
  logic [28:0] cur_field = '0;
  logic [2:0]  cur_wire = '0;
  logic [31:0] skip_left = '0;
  logic [28:0] group_fields [STACK_DEPTH];
  int          open_groups = 0;
  logic        parser_failed = 1'b0;
  logic [6:0]  nest_limit = NEST_RESET;

  field_report_t predicted_reports [$];
  logic [7:0]    msg [$];

  int send_idle_pct = 36;
  int recv_stall_pct = 52;
  int mismatches = 0;
  int reports_checked = 0;
  int bytes_sent = 0;
  int msgs_sent = 0;
  int error_case = -1;
  logic [2:0] last_status = ST_OK;

  protobuf_wire_field_skipper_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic vint_step_t take_varint(input logic [7:0] b, output logic [63:0] v);
    int sh;
    sh = 7 * vbytes;
    v = '0;
    if (sh < 64) vacc |= {57'd0, b[6:0]} << sh;
    vbytes++;
    if (b[7]) begin
      if (vbytes >= 10) begin
        vacc = '0;
        vbytes = 0;
        return VINT_TOO_LONG;
      end
      return VINT_MORE;
    end
    v = vacc;
    vacc = '0;
    vbytes = 0;
    return VINT_DONE;
  endfunction

  // Advances the predicted parser by one byte and queues the report it causes.
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    field_report_t r;
    logic [63:0] v;
    vint_step_t k;
    logic err;
    logic done;
    int lim;
    if (parser_failed) return;
    r = '0;
    err = 1'b0;
    done = 1'b0;
    if (ph != PH_TAG) begin
      r.fnum = cur_field;
      r.wkind = cur_wire;
    end
    case (ph)
      PH_TAG: begin
        k = take_varint(b, v);
        if (k == VINT_TOO_LONG) begin
          err = 1'b1;
          r.status = ST_LONG_VINT;
        end else if (k == VINT_DONE) begin
          if (v > 64'hFFFF_FFFF) begin
            err = 1'b1;
            r.status = ST_OVER_32;
          end else begin
            cur_field = v[31:3];
            cur_wire = v[2:0];
            r.fnum = cur_field;
            r.wkind = cur_wire;
            if (cur_field == 0) begin
              err = 1'b1;
              r.status = ST_FIELD_ZERO;
            end else begin
              case (cur_wire)
                WT_VARINT: ph = PH_VALUE;
                WT_FIXED64: begin
                  skip_left = 32'd8;
                  ph = PH_SKIP;
                end
                WT_FIXED32: begin
                  skip_left = 32'd4;
                  ph = PH_SKIP;
                end
                WT_LENGTH: ph = PH_LENGTH;
                WT_SGROUP: begin
                  lim = (int'(nest_limit) > STACK_DEPTH) ? STACK_DEPTH : int'(nest_limit);
                  if (open_groups >= lim) begin
                    err = 1'b1;
                    r.status = ST_TOO_DEEP;
                  end else begin
                    group_fields[open_groups] = cur_field;
                    open_groups++;
                    done = 1'b1;
                  end
                end
                WT_EGROUP: begin
                  if (open_groups > 0 && group_fields[open_groups-1] == cur_field) begin
                    open_groups--;
                    done = 1'b1;
                  end else begin
                    err = 1'b1;
                    r.status = ST_UNMATCHED;
                  end
                end
                default: begin
                  err = 1'b1;
                  r.status = ST_BAD_WIRE;
                end
              endcase
            end
          end
        end
      end
      PH_VALUE: begin
        k = take_varint(b, v);
        if (k == VINT_TOO_LONG) begin
          err = 1'b1;
          r.status = ST_LONG_VINT;
        end else if (k == VINT_DONE) begin
          ph = PH_TAG;
          done = 1'b1;
        end
      end
      PH_LENGTH: begin
        k = take_varint(b, v);
        if (k == VINT_TOO_LONG) begin
          err = 1'b1;
          r.status = ST_LONG_VINT;
        end else if (k == VINT_DONE) begin
          if (v > 64'hFFFF_FFFF) begin
            err = 1'b1;
            r.status = ST_OVER_32;
          end else if (v == 0) begin
            ph = PH_TAG;
            done = 1'b1;
          end else begin
            skip_left = v[31:0];
            ph = PH_SKIP;
          end
        end
      end
      default: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) begin
          ph = PH_TAG;
          done = 1'b1;
        end
      end
    endcase
    if (!err) begin
      if (done) begin
        if (last && open_groups > 0) begin
          err = 1'b1;
          r.status = ST_UNEXP_END;
        end
      end else begin
        if (!last) return;
        err = 1'b1;
        r.status = ST_UNEXP_END;
      end
    end
    if (err) parser_failed = 1'b1;
    r.depth = 7'(open_groups);
    r.done = last;
    predicted_reports.push_back(r);
  endfunction

  function automatic void put_varint(input logic [63:0] v, input int pad);
    int n;
    logic [63:0] t;
    n = 1;
    t = v >> 7;
    while (t != 0) begin
      n++;
      t = t >> 7;
    end
    n = n + pad;
    if (n > 10) n = 10;
    for (int i = 0; i < n; i++) msg.push_back({i < n - 1, 7'(v >> (7 * i))});
  endfunction

  function automatic int random_pad();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0;
  endfunction

  function automatic void put_tag(input logic [28:0] fn, input logic [2:0] wt, input int pad);
    put_varint({32'd0, fn, wt}, pad);
  endfunction

  function automatic logic [28:0] random_field_number();
    case ($urandom_range(0, 3))
      0: return 29'($urandom_range(1, 15));
      1: return 29'($urandom_range(16, 2047));
      2: return 29'(($urandom % 32'h1FFF_FFFF) + 1);
      default: return 29'h1FFF_FFFF;
    endcase
  endfunction

  // One complete field of a random wire type with random content.
  function automatic void put_field();
    logic [2:0] wt;
    int n;
    case ($urandom_range(0, 3))
      0: wt = WT_VARINT;
      1: wt = WT_FIXED64;
      2: wt = WT_LENGTH;
      default: wt = WT_FIXED32;
    endcase
    put_tag(random_field_number(), wt, random_pad());
    case (wt)
      WT_VARINT: begin
        n = ($urandom_range(0, 3) == 0) ? 10 : $urandom_range(1, 3);
        for (int i = 0; i < n; i++) msg.push_back({i < n - 1, 7'($urandom)});
      end
      WT_FIXED64: repeat (8) msg.push_back(8'($urandom));
      WT_FIXED32: repeat (4) msg.push_back(8'($urandom));
      default: begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 12);
        put_varint(64'(n), random_pad());
        repeat (n) msg.push_back(8'($urandom));
      end
    endcase
  endfunction

  // A well-formed message whose groups never nest deeper than max_depth.
  function automatic void build_message(input int max_depth);
    logic [28:0] open_fn [$];
    logic [28:0] fn;
    int n;
    int pick;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20 && open_fn.size() < max_depth) begin
        fn = random_field_number();
        open_fn.push_back(fn);
        put_tag(fn, WT_SGROUP, random_pad());
      end else if (pick < 40 && open_fn.size() > 0) begin
        put_tag(open_fn.pop_back(), WT_EGROUP, random_pad());
      end else begin
        put_field();
      end
    end
    while (open_fn.size() > 0) put_tag(open_fn.pop_back(), WT_EGROUP, random_pad());
  endfunction

  // Groups nested exactly levels deep around one field.
  function automatic void nest_groups(input int levels);
    logic [28:0] open_fn [$];
    for (int i = 0; i < levels; i++) begin
      open_fn.push_back(random_field_number());
      put_tag(open_fn[i], WT_SGROUP, 0);
    end
    put_field();
    while (open_fn.size() > 0) put_tag(open_fn.pop_back(), WT_EGROUP, 0);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_msg(input logic last_at_end);
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], last_at_end && i == msg.size() - 1);
    msg.delete();
    msgs_sent++;
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (predicted_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_nesting_limit(input logic [6:0] value);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    nest_limit = value;
  endtask

  function automatic int current_depth_cap();
    return (int'(nest_limit) > STACK_DEPTH) ? STACK_DEPTH : int'(nest_limit);
  endfunction

  task automatic report_mismatch(input string name, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
  endtask

  always @(posedge clk) begin : check_reports
    field_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_reports.size() == 0) begin
        report_mismatch("unexpected report, tdata", 0, m_tdata);
      end else begin
        want = predicted_reports.pop_front();
        reports_checked++;
        last_status = m_tdata[41:39];
        if (m_tdata[28:0] !== want.fnum) report_mismatch("field_number", want.fnum, m_tdata[28:0]);
        if (m_tdata[31:29] !== want.wkind) report_mismatch("wire_kind", want.wkind, m_tdata[31:29]);
        if (m_tdata[38:32] !== want.depth) report_mismatch("nest_depth", want.depth, m_tdata[38:32]);
        if (m_tdata[41:39] !== want.status) report_mismatch("status", want.status, m_tdata[41:39]);
        if (m_tlast !== want.done) report_mismatch("message_done", want.done, m_tlast);
      end
    end
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic test_directed_fields();
    put_tag(29'd1, WT_VARINT, 0);
    msg.push_back(8'h00);
    put_tag(29'h1FFF_FFFF, WT_FIXED32, 0);
    repeat (4) msg.push_back(8'hFF);
    put_tag(29'd2, WT_FIXED64, 1);
    repeat (8) msg.push_back(8'h00);
    // A zero length completes the field on the length byte itself.
    put_tag(29'd3, WT_LENGTH, 0);
    put_varint(64'd0, 0);
    put_tag(29'd4, WT_LENGTH, 0);
    put_varint(64'd2, 0);
    msg.push_back(8'hA5);
    msg.push_back(8'h5A);
    // Ten-byte varint whose top byte carries bits beyond bit 63.
    put_tag(29'd5, WT_VARINT, 0);
    repeat (9) msg.push_back(8'hFF);
    msg.push_back(8'h7F);
    put_tag(29'd6, WT_SGROUP, 0);
    put_tag(29'd7, WT_VARINT, 0);
    msg.push_back(8'h01);
    put_tag(29'd6, WT_EGROUP, 0);
    send_msg(1'b1);
  endtask

  task automatic test_nesting_limits();
    set_nesting_limit(7'd1);
    nest_groups(1);
    send_msg(1'b1);
    repeat (4) begin
      build_message(1);
      send_msg(1'b1);
    end
    // Values above the stack size are held to the stack size.
    set_nesting_limit(7'd127);
    nest_groups(STACK_DEPTH);
    send_msg(1'b1);
    set_nesting_limit(7'd37);
    nest_groups(37);
    send_msg(1'b1);
  endtask

  task automatic test_random_traffic();
    int part_start;
    int max_depth;
    for (int part = 0; part < 3; part++) begin
      case (part)
        0: begin
          send_idle_pct = 36;
          recv_stall_pct = 52;
          set_nesting_limit(7'($urandom_range(2, 63)));
        end
        1: begin
          send_idle_pct = 52;
          recv_stall_pct = 36;
          set_nesting_limit(NEST_RESET);
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          set_nesting_limit(7'($urandom_range(1, 127)));
        end
      endcase
      part_start = bytes_sent;
      while (bytes_sent - part_start < PART_BYTES) begin
        max_depth = current_depth_cap();
        if ($urandom_range(0, 9) != 0 && max_depth > 3) max_depth = 3;
        build_message(max_depth);
        send_msg(1'b1);
        if ($urandom_range(0, 29) == 0) wait_results_drained();
      end
    end
  endtask

  // The block stays silent after its first error, so only one error is provoked.
  task automatic test_error_and_silence();
    logic [28:0] fn;
    int tries;
    error_case = $urandom_range(ERR_FIELD_ZERO, ERR_NOISE);
    fn = 29'($urandom_range(1, 1000));
    case (error_case) inside
      ERR_FIELD_ZERO: put_varint(64'($urandom_range(0, 7)), random_pad());
      ERR_BAD_WIRE: put_tag(random_field_number(), 3'($urandom_range(6, 7)), random_pad());
      ERR_LONG_TAG: repeat (10) msg.push_back(8'h80 | 8'($urandom));
      ERR_LONG_VALUE: begin
        put_tag(fn, WT_VARINT, 0);
        repeat (10) msg.push_back(8'h80 | 8'($urandom));
      end
      ERR_TAG_OVER_32, ERR_LEN_OVER_32: begin
        if (error_case == ERR_LEN_OVER_32) put_tag(fn, WT_LENGTH, 0);
        repeat (4) msg.push_back(8'h80 | 8'($urandom));
        msg.push_back(8'($urandom_range(16, 127)));
      end
      ERR_UNMATCHED: begin
        if ($urandom_range(0, 1) == 1) put_tag(fn, WT_SGROUP, 0);
        put_tag(fn + 29'd1, WT_EGROUP, 0);
      end
      ERR_TOO_DEEP: begin
        // A limit of zero refuses every start-group.
        if ($urandom_range(0, 1) == 1) set_nesting_limit(7'd0);
        for (int i = 0; i <= current_depth_cap(); i++) put_tag(random_field_number(), WT_SGROUP, 0);
      end
      ERR_EARLY_END: begin
        case ($urandom_range(0, 3))
          0: begin
            put_tag(fn, WT_FIXED64, 0);
            repeat (3) msg.push_back(8'($urandom));
          end
          1: begin
            put_tag(fn, WT_SGROUP, 0);
            put_field();
          end
          2: msg.push_back(8'h80);
          default: begin
            put_tag(fn, WT_VARINT, 0);
            msg.push_back(8'h80);
          end
        endcase
        send_msg(1'b1);
      end
      default: begin
        tries = 0;
        while (!parser_failed && tries < 400) begin
          send_byte(8'($urandom), $urandom_range(0, 15) == 0);
          tries++;
        end
      end
    endcase
    if (msg.size() != 0) send_msg(1'($urandom_range(0, 1)));
    repeat (16) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_fields();
    test_nesting_limits();
    test_random_traffic();
    test_error_and_silence();
    s_tvalid <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes in %0d messages; %0d field reports checked across three idle mixes.",
             bytes_sent, msgs_sent, reports_checked);
    $display("Closing error case %0d gave status %0d, then the parser stayed silent.",
             error_case, last_status);
    if (mismatches == 0 && predicted_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timed out with %0d reports outstanding.", predicted_reports.size());
    $display("status: fail");
    $finish;
  end

endmodule
